### rtl/rsos_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range scan object segmenter package
// Shared constants, register codes and record types of the segmenter.
// ----------------------------------------------------------------------------
package rsos_pkg;

    // Default sizes of a sweep
    localparam int MAX_OBJECTS_DEF = 5;
    localparam int MAX_SAMPLES_DEF = 91;

    // Start and end index reported when no object has been stored
    localparam logic [7:0] NO_OBJECT_IDX = 8'd181;

    // Register reset values
    localparam logic [15:0] TOLERANCE_RST  = 16'd64;
    localparam logic [15:0] NEAR_LIMIT_RST = 16'd960;
    localparam logic [7:0]  MIN_POINTS_RST = 8'd4;
    localparam logic [7:0]  SMALL_LIM_RST  = 8'd10;

    // Register word indexes
    localparam logic [1:0] REG_TOLERANCE  = 2'd0;
    localparam logic [1:0] REG_NEAR_LIMIT = 2'd1;
    localparam logic [1:0] REG_MIN_POINTS = 2'd2;
    localparam logic [1:0] REG_SMALL_LIM  = 2'd3;

    // Record kinds
    localparam logic KIND_OBJECT  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [15:0] tolerance;
        logic [15:0] near_limit;
        logic [7:0]  min_points;
        logic [7:0]  small_size_limit;
    } t_cfg;

    typedef struct packed {
        logic       record_kind;
        logic [2:0] slot;
        logic [7:0] start_index;
        logic [7:0] end_index;
        logic [7:0] span;
        logic [8:0] center_sum;
        logic       stored;
        logic       last;
    } t_rec;

    // Everything one sample causes: an optional object and an optional summary
    typedef struct packed {
        logic obj_vld;
        t_rec obj;
        logic sum_vld;
        t_rec sum;
    } t_entry;

endpackage

### rtl/rsos_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segmenter register bank
// APB-style register file holding the segmentation thresholds.
// ----------------------------------------------------------------------------
module rsos_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output rsos_pkg::t_cfg o_cfg
);

    rsos_pkg::t_cfg r_cfg;
    rsos_pkg::t_cfg n_cfg;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (paddr[3:2])
                rsos_pkg::REG_TOLERANCE:  n_cfg.tolerance        = pwdata[15:0];
                rsos_pkg::REG_NEAR_LIMIT: n_cfg.near_limit       = pwdata[15:0];
                rsos_pkg::REG_MIN_POINTS: n_cfg.min_points       = pwdata[7:0];
                rsos_pkg::REG_SMALL_LIM:  n_cfg.small_size_limit = pwdata[7:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tolerance        <= rsos_pkg::TOLERANCE_RST;
            r_cfg.near_limit       <= rsos_pkg::NEAR_LIMIT_RST;
            r_cfg.min_points       <= rsos_pkg::MIN_POINTS_RST;
            r_cfg.small_size_limit <= rsos_pkg::SMALL_LIM_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (paddr[3:2])
            rsos_pkg::REG_TOLERANCE:  prdata = {16'd0, r_cfg.tolerance};
            rsos_pkg::REG_NEAR_LIMIT: prdata = {16'd0, r_cfg.near_limit};
            rsos_pkg::REG_MIN_POINTS: prdata = {24'd0, r_cfg.min_points};
            rsos_pkg::REG_SMALL_LIM:  prdata = {24'd0, r_cfg.small_size_limit};
            default:                  prdata = 32'd0;
        endcase
    end

endmodule

### rtl/rsos_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segmenter front end
// Accepts samples, tracks the open run and the smallest object, and builds
// the records each sample causes.
// ----------------------------------------------------------------------------
module rsos_front #(
    parameter int MAX_OBJECTS = rsos_pkg::MAX_OBJECTS_DEF,
    parameter int MAX_SAMPLES = rsos_pkg::MAX_SAMPLES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rsos_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    input  logic [15:0]     i_distance,
    input  logic            i_final,
    output logic            o_ready,
    input  logic            i_q_full,
    output logic            o_push,
    output rsos_pkg::t_entry o_entry
);

    localparam logic [7:0] LastIdx = 8'(MAX_SAMPLES - 1);
    localparam logic [2:0] ObjMax  = 3'(MAX_OBJECTS);

    logic [15:0] r_prev, n_prev;
    logic [7:0]  r_idx, n_idx;
    logic        r_open, n_open;
    logic [7:0]  r_run_start, n_run_start;
    logic [7:0]  r_points, n_points;
    logic [2:0]  r_objs, n_objs;
    logic [2:0]  r_best_slot, n_best_slot;
    logic [7:0]  r_best_span, n_best_span;
    logic [7:0]  r_best_start, n_best_start;
    logic [7:0]  r_best_end, n_best_end;

    logic        accept;
    logic        fin;
    logic [15:0] step;
    logic        cont;
    logic        obj_hit;
    logic [7:0]  st;
    logic [7:0]  sp;
    logic        stored;
    logic        any;
    rsos_pkg::t_entry entry;

    assign o_ready = ~i_q_full;
    assign accept  = i_valid & ~i_q_full;

    always_comb begin
        n_prev       = r_prev;
        n_idx        = r_idx;
        n_open       = r_open;
        n_run_start  = r_run_start;
        n_points     = r_points;
        n_objs       = r_objs;
        n_best_slot  = r_best_slot;
        n_best_span  = r_best_span;
        n_best_start = r_best_start;
        n_best_end   = r_best_end;
        entry        = '0;

        fin    = i_final | (r_idx >= LastIdx);
        step   = (i_distance >= r_prev) ? (i_distance - r_prev) : (r_prev - i_distance);
        cont   = (step <= i_cfg.tolerance) & (i_distance < i_cfg.near_limit) & ~fin;
        obj_hit = (r_idx != 8'd0) & ~cont & r_open & (r_points >= i_cfg.min_points);
        st     = r_run_start - 8'd1;
        sp     = r_idx - st;
        stored = r_objs < ObjMax;

        if (r_idx != 8'd0) begin
            if (cont) begin
                if (!r_open) begin
                    n_run_start = r_idx;
                    n_open      = 1'b1;
                end
                if (r_points != 8'hFF) begin
                    n_points = r_points + 8'd1;
                end
            end else begin
                n_open   = 1'b0;
                n_points = 8'd1;
            end
        end

        if (obj_hit) begin
            entry.obj_vld          = 1'b1;
            entry.obj.record_kind  = rsos_pkg::KIND_OBJECT;
            entry.obj.slot         = stored ? r_objs : 3'd0;
            entry.obj.start_index  = st;
            entry.obj.end_index    = r_idx;
            entry.obj.span         = sp;
            entry.obj.center_sum   = {1'b0, st} + {1'b0, r_idx};
            entry.obj.stored       = stored;
            entry.obj.last         = ~fin;
            if (stored) begin
                if ((r_objs == 3'd0) ||
                    ((sp < r_best_span) && (sp < i_cfg.small_size_limit))) begin
                    n_best_slot  = r_objs;
                    n_best_span  = sp;
                    n_best_start = st;
                    n_best_end   = r_idx;
                end
                n_objs = r_objs + 3'd1;
            end
        end

        n_prev = i_distance;
        any    = n_objs != 3'd0;

        if (fin) begin
            entry.sum_vld         = 1'b1;
            entry.sum.record_kind = rsos_pkg::KIND_SUMMARY;
            entry.sum.slot        = n_best_slot;
            entry.sum.start_index = n_best_start;
            entry.sum.end_index   = n_best_end;
            entry.sum.span        = any ? n_best_span : 8'd0;
            entry.sum.center_sum  = any ? ({1'b0, n_best_start} + {1'b0, n_best_end})
                                        : 9'd0;
            entry.sum.stored      = any;
            entry.sum.last        = 1'b1;
            // New sweep starts with the next sample
            n_idx        = 8'd0;
            n_open       = 1'b0;
            n_run_start  = 8'd0;
            n_points     = 8'd0;
            n_objs       = 3'd0;
            n_best_slot  = 3'd0;
            n_best_span  = 8'd0;
            n_best_start = rsos_pkg::NO_OBJECT_IDX;
            n_best_end   = rsos_pkg::NO_OBJECT_IDX;
        end else begin
            n_idx = r_idx + 8'd1;
        end
    end

    assign o_push  = accept & (entry.obj_vld | entry.sum_vld);
    assign o_entry = entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev       <= 16'd0;
            r_idx        <= 8'd0;
            r_open       <= 1'b0;
            r_run_start  <= 8'd0;
            r_points     <= 8'd0;
            r_objs       <= 3'd0;
            r_best_slot  <= 3'd0;
            r_best_span  <= 8'd0;
            r_best_start <= rsos_pkg::NO_OBJECT_IDX;
            r_best_end   <= rsos_pkg::NO_OBJECT_IDX;
        end else if (accept) begin
            r_prev       <= n_prev;
            r_idx        <= n_idx;
            r_open       <= n_open;
            r_run_start  <= n_run_start;
            r_points     <= n_points;
            r_objs       <= n_objs;
            r_best_slot  <= n_best_slot;
            r_best_span  <= n_best_span;
            r_best_start <= n_best_start;
            r_best_end   <= n_best_end;
        end
    end

endmodule

### rtl/rsos_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segmenter record queue
// Small first-in first-out queue of record entries between front and back.
// ----------------------------------------------------------------------------
module rsos_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rsos_pkg::t_entry i_entry,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output rsos_pkg::t_entry o_entry
);

    localparam int PtrW = $clog2(rsos_pkg::QUEUE_DEPTH);
    localparam int CntW = $clog2(rsos_pkg::QUEUE_DEPTH + 1);

    rsos_pkg::t_entry r_mem [rsos_pkg::QUEUE_DEPTH];
    logic [PtrW-1:0]  r_wr, r_rd;
    logic [CntW-1:0]  r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = r_cnt == CntW'(rsos_pkg::QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_entry = r_mem[r_rd];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + PtrW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + PtrW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CntW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CntW'(1);
            end
        end
    end

endmodule

### rtl/rsos_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segmenter back end
// Output register that takes one entry from the queue and sends its object
// record and summary record one after the other.
// ----------------------------------------------------------------------------
module rsos_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  rsos_pkg::t_entry i_q_entry,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output rsos_pkg::t_rec   o_rec
);

    logic           r_obj_v;
    logic           r_sum_v;
    rsos_pkg::t_rec r_obj;
    rsos_pkg::t_rec r_sum;
    logic           busy;
    logic           hs;
    logic           done;

    assign busy    = r_obj_v | r_sum_v;
    assign hs      = busy & i_ready;
    // The entry is finished when the record going out now is its last one
    assign done    = hs & ~(r_obj_v & r_sum_v);
    assign o_pop   = i_q_valid & (~busy | done);
    assign o_valid = busy;
    assign o_rec   = r_obj_v ? r_obj : r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obj_v <= 1'b0;
            r_sum_v <= 1'b0;
        end else if (o_pop) begin
            r_obj_v <= i_q_entry.obj_vld;
            r_sum_v <= i_q_entry.sum_vld;
        end else if (hs) begin
            if (r_obj_v) begin
                r_obj_v <= 1'b0;
            end else begin
                r_sum_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_obj <= i_q_entry.obj;
            r_sum <= i_q_entry.sum;
        end
    end

endmodule

### rtl/range_scan_object_segmenter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range scan object segmenter
// Splits a sweep of range samples into objects and reports each object and
// the smallest one at the end of the sweep.
// ----------------------------------------------------------------------------
// One range sample is taken per cycle on the slave stream (distance in tdata,
// the end of the sweep in tlast) as long as the four-entry record queue has
// room. A sample that closes a long enough run yields an object record; the
// final sample of a sweep, or the sample at index MAX_SAMPLES - 1, yields a
// summary record naming the first stored object or a later, smaller one below
// the small size limit, so one sample yields zero, one or two records. Records
// leave the master stream at one per cycle while the master is ready, from the
// output register that the queue feeds; a sample with two records sends them
// one after the other. The queue absorbs such bursts and short stalls
// downstream; the input is held off only once all four queue entries are
// waiting, and it resumes in the cycle after the output side takes one. The
// thresholds are set through the APB port and should only be changed between
// sweeps while no record is pending.
// ----------------------------------------------------------------------------
module range_scan_object_segmenter #(
    parameter int MAX_OBJECTS = rsos_pkg::MAX_OBJECTS_DEF,
    parameter int MAX_SAMPLES = rsos_pkg::MAX_SAMPLES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Sample stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] distance
    input  logic        s_axis_tlast,   // final_sample
    // Record stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [2:0] slot, [10:3] start_index,
                                        // [18:11] end_index, [26:19] span,
                                        // [35:27] center_sum, [36] stored,
                                        // [39:37] zero
    output logic        m_axis_tuser,   // record_kind
    output logic        m_axis_tlast,   // last
    // Register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    rsos_pkg::t_cfg   cfg;
    rsos_pkg::t_entry push_entry;
    rsos_pkg::t_entry head_entry;
    rsos_pkg::t_rec   out_rec;
    logic             push;
    logic             q_full;
    logic             q_valid;
    logic             pop;

    // Threshold registers
    rsos_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Front end: run tracking and record building, one sample per cycle while the queue has room
    rsos_front #(
        .MAX_OBJECTS (MAX_OBJECTS),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_valid    (s_axis_tvalid),
        .i_distance (s_axis_tdata),
        .i_final    (s_axis_tlast),
        .o_ready    (s_axis_tready),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    // Queue decoupling the front end from the output side
    rsos_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    // Back end: sends the records of each entry in order
    rsos_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (head_entry),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_rec     (out_rec)
    );

    assign m_axis_tdata = {3'd0, out_rec.stored, out_rec.center_sum, out_rec.span,
                           out_rec.end_index, out_rec.start_index, out_rec.slot};
    assign m_axis_tuser = out_rec.record_kind;
    assign m_axis_tlast = out_rec.last;

endmodule

### rtl/rsos_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segmenter port checker
// Assertions on the record stream as seen at the top-level ports.
// ----------------------------------------------------------------------------
module rsos_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // A waiting record is not withdrawn
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("record withdrawn while stalled");

    // The summary closes the records of its sample
    a_sum_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == rsos_pkg::KIND_SUMMARY |-> m_axis_tlast)
        else $error("summary record without last");

    // An object that found no slot reports slot zero
    a_unstored_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == rsos_pkg::KIND_OBJECT && !m_axis_tdata[36]
        |-> m_axis_tdata[2:0] == 3'd0)
        else $error("unstored object with non-zero slot");

    // Object span and centre follow from its start and end
    a_obj_geom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == rsos_pkg::KIND_OBJECT
        |-> m_axis_tdata[26:19] == 8'(m_axis_tdata[18:11] - m_axis_tdata[10:3])
            && m_axis_tdata[35:27] == ({1'b0, m_axis_tdata[18:11]}
                                       + {1'b0, m_axis_tdata[10:3]}))
        else $error("object span or centre inconsistent");

    // No record is offered straight after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("record offered after reset");

endmodule

bind range_scan_object_segmenter rsos_checker u_rsos_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
